### rtl/pipe_bend_coordinate_warp_core_macros.svh
`ifndef PIPE_BEND_COORDINATE_WARP_CORE_MACROS_SVH
`define PIPE_BEND_COORDINATE_WARP_CORE_MACROS_SVH

// same-cycle implication, masked while in reset
`define BCW_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bcw: same-cycle check failed");

// next-cycle implication, masked while in reset
`define BCW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bcw: next-cycle check failed");

// condition checked in the cycle after reset is seen
`define BCW_ASSERT_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error("bcw: reset check failed");

`endif

### rtl/bcw_pkg.sv
`timescale 1ns / 1ps
package bcw_pkg;

  localparam int COORD_W    = 32;
  localparam int RADIUS_W   = COORD_W - 1;
  localparam int ANG_BITS   = 30;
  localparam int DIV_CELLS  = ANG_BITS;
  localparam int CORDIC_N   = 16;
  localparam int STEP_W     = 5;
  localparam int LEN_W      = 33;
  localparam int REM_W      = 34;
  localparam int ANG_W      = 34;

  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic signed [ANG_W-1:0] GAIN_Q30 = 34'sd652032874;
  localparam logic [RADIUS_W-1:0] RADIUS_RST = 31'd65536;

  typedef enum logic [1:0] {
    MODE_PASS,
    MODE_BEND,
    MODE_STRAIGHT
  } mode_t;

  typedef struct packed {
    mode_t                    mode;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [LEN_W-1:0]         len;
    logic [REM_W-1:0]         rem;
    logic [ANG_BITS-1:0]      frac;
    logic signed [ANG_W-1:0]  z;
    logic signed [ANG_W-1:0]  cx;
    logic signed [ANG_W-1:0]  cy;
  } item_t;

  function automatic logic signed [ANG_W-1:0] atan_q30(input logic [STEP_W-1:0] idx);
    logic signed [ANG_W-1:0] a;
    unique case (idx)
      5'd0:  a = 34'sd843314857;
      5'd1:  a = 34'sd497837829;
      5'd2:  a = 34'sd263043837;
      5'd3:  a = 34'sd133525159;
      5'd4:  a = 34'sd67021687;
      5'd5:  a = 34'sd33543516;
      5'd6:  a = 34'sd16775851;
      5'd7:  a = 34'sd8388437;
      5'd8:  a = 34'sd4194283;
      5'd9:  a = 34'sd2097149;
      5'd31: a = 34'sd1;
      default: a = 34'sd1 <<< (5'd30 - idx);
    endcase
    return a;
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [35:0] v);
    logic signed [35:0] hi;
    logic signed [35:0] lo;
    hi = 36'sd2147483647;
    lo = -36'sd2147483648;
    if (v > hi) return 32'sh7fffffff;
    if (v < lo) return 32'sh80000000;
    return v[COORD_W-1:0];
  endfunction

endpackage

### rtl/bcw_ifs.sv
`timescale 1ns / 1ps
interface bcw_in_if;
  logic valid;
  logic ready;
  logic signed [bcw_pkg::COORD_W-1:0] coord_x;
  logic signed [bcw_pkg::COORD_W-1:0] coord_y;
  modport source (output valid, coord_x, coord_y, input ready);
  modport sink (input valid, coord_x, coord_y, output ready);
endinterface

interface bcw_out_if;
  logic valid;
  logic ready;
  logic signed [bcw_pkg::COORD_W-1:0] bent_x;
  logic signed [bcw_pkg::COORD_W-1:0] bent_y;
  modport source (output valid, bent_x, bent_y, input ready);
  modport sink (input valid, bent_x, bent_y, output ready);
endinterface

### rtl/bcw_front.sv
`timescale 1ns / 1ps
module bcw_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [bcw_pkg::RADIUS_W-1:0]       bend_radius,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [bcw_pkg::COORD_W-1:0] in_x,
  input  logic signed [bcw_pkg::COORD_W-1:0] in_y,
  output logic                               dn_valid,
  input  logic                               dn_ready,
  output bcw_pkg::item_t                     dn_item
);

  logic        va_r, vb_r, vc_r;
  logic        rdy_a, rdy_b, rdy_c;
  logic signed [bcw_pkg::COORD_W-1:0] xa_r, ya_r, xb_r, yb_r;
  logic [46:0] ph_r;
  logic [45:0] pl_r;
  logic [bcw_pkg::LEN_W-1:0] len_r;
  logic [62:0] len_sum;
  logic signed [bcw_pkg::REM_W-1:0] diff;
  bcw_pkg::item_t item_r, item_nxt;

  assign rdy_c    = !vc_r || dn_ready;
  assign rdy_b    = !vb_r || rdy_c;
  assign rdy_a    = !va_r || rdy_b;
  assign in_ready = rdy_a;
  assign dn_valid = vc_r;
  assign dn_item  = item_r;

  assign len_sum = {1'b0, ph_r, 15'b0} + {17'b0, pl_r} + (63'd1 << 29);

  always_comb begin
    diff = $signed({1'b0, len_r}) - $signed({{2{xb_r[bcw_pkg::COORD_W-1]}}, xb_r});
    item_nxt      = '0;
    item_nxt.x    = xb_r;
    item_nxt.y    = yb_r;
    item_nxt.len  = len_r;
    item_nxt.rem  = diff;
    if (xb_r <= 0) begin
      item_nxt.mode = bcw_pkg::MODE_PASS;
    end else if (diff >= 0) begin
      item_nxt.mode = bcw_pkg::MODE_BEND;
    end else begin
      item_nxt.mode = bcw_pkg::MODE_STRAIGHT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= in_valid;
      if (rdy_b) vb_r <= va_r;
      if (rdy_c) vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      xa_r <= in_x;
      ya_r <= in_y;
      ph_r <= bend_radius * bcw_pkg::HALF_PI_Q30[30:15];
      pl_r <= bend_radius * bcw_pkg::HALF_PI_Q30[14:0];
    end
    if (rdy_b) begin
      xb_r  <= xa_r;
      yb_r  <= ya_r;
      len_r <= len_sum[62:30];
    end
    if (rdy_c) item_r <= item_nxt;
  end

endmodule

### rtl/bcw_div_cell.sv
`timescale 1ns / 1ps
module bcw_div_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_ready,
  input  bcw_pkg::item_t up_item,
  output logic           dn_valid,
  input  logic           dn_ready,
  output bcw_pkg::item_t dn_item
);

  logic           v_r;
  bcw_pkg::item_t item_r, item_nxt;
  logic [bcw_pkg::REM_W-1:0] rem2;
  logic           ge;

  assign up_ready = !v_r || dn_ready;
  assign dn_valid = v_r;
  assign dn_item  = item_r;

  always_comb begin
    rem2     = {up_item.rem[bcw_pkg::REM_W-2:0], 1'b0};
    ge       = rem2 >= {1'b0, up_item.len};
    item_nxt = up_item;
    item_nxt.frac = {up_item.frac[bcw_pkg::ANG_BITS-2:0], ge};
    item_nxt.rem  = ge ? rem2 - {1'b0, up_item.len} : rem2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) item_r <= item_nxt;
  end

endmodule

### rtl/bcw_angle.sv
`timescale 1ns / 1ps
module bcw_angle (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_ready,
  input  bcw_pkg::item_t up_item,
  output logic           dn_valid,
  input  logic           dn_ready,
  output bcw_pkg::item_t dn_item
);

  logic           v_r;
  bcw_pkg::item_t item_r, item_nxt;
  logic [60:0]    prod;

  assign up_ready = !v_r || dn_ready;
  assign dn_valid = v_r;
  assign dn_item  = item_r;

  always_comb begin
    prod     = up_item.frac * bcw_pkg::HALF_PI_Q30 + (61'd1 << 29);
    item_nxt = up_item;
    item_nxt.z  = $signed({3'b0, prod[60:30]});
    item_nxt.cx = bcw_pkg::GAIN_Q30;
    item_nxt.cy = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) item_r <= item_nxt;
  end

endmodule

### rtl/bcw_cordic_cell.sv
`timescale 1ns / 1ps
module bcw_cordic_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [bcw_pkg::STEP_W-1:0]  step,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  bcw_pkg::item_t              up_item,
  output logic                        dn_valid,
  input  logic                        dn_ready,
  output bcw_pkg::item_t              dn_item
);

  logic           v_r;
  bcw_pkg::item_t item_r, item_nxt;
  logic signed [bcw_pkg::ANG_W-1:0] dx, dy, ang;

  assign up_ready = !v_r || dn_ready;
  assign dn_valid = v_r;
  assign dn_item  = item_r;

  always_comb begin
    dx       = up_item.cy >>> step;
    dy       = up_item.cx >>> step;
    ang      = bcw_pkg::atan_q30(step);
    item_nxt = up_item;
    if (up_item.z >= 0) begin
      item_nxt.cx = up_item.cx - dx;
      item_nxt.cy = up_item.cy + dy;
      item_nxt.z  = up_item.z - ang;
    end else begin
      item_nxt.cx = up_item.cx + dx;
      item_nxt.cy = up_item.cy - dy;
      item_nxt.z  = up_item.z + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) item_r <= item_nxt;
  end

endmodule

### rtl/bcw_back.sv
`timescale 1ns / 1ps
module bcw_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               up_valid,
  output logic                               up_ready,
  input  bcw_pkg::item_t                     up_item,
  output logic                               dn_valid,
  input  logic                               dn_ready,
  output logic signed [bcw_pkg::COORD_W-1:0] dn_x,
  output logic signed [bcw_pkg::COORD_W-1:0] dn_y
);

  logic        va_r, vb_r, rdy_a, rdy_b;
  logic [32:0] ay, acx, acy;
  logic [63:0] pa_r, pb_r;
  logic        nega_r, negb_r;
  bcw_pkg::mode_t mode_r;
  logic signed [bcw_pkg::COORD_W-1:0] x_r, y_r, bx_r, by_r, bx_nxt, by_nxt;
  logic [bcw_pkg::LEN_W-1:0] len_r;
  logic [64:0] ra, rb;
  logic signed [35:0] sa, sb, dstr;

  assign rdy_b    = !vb_r || dn_ready;
  assign rdy_a    = !va_r || rdy_b;
  assign up_ready = rdy_a;
  assign dn_valid = vb_r;
  assign dn_x     = bx_r;
  assign dn_y     = by_r;

  always_comb begin
    ay  = up_item.y[31] ? -{1'b1, up_item.y} : {1'b0, up_item.y};
    acx = up_item.cx[33] ? 33'(-up_item.cx) : 33'(up_item.cx);
    acy = up_item.cy[33] ? 33'(-up_item.cy) : 33'(up_item.cy);
  end

  always_comb begin
    ra   = {1'b0, pa_r} + (65'd1 << 29);
    rb   = {1'b0, pb_r} + (65'd1 << 29);
    sa   = nega_r ? -$signed({1'b0, ra[64:30]}) : $signed({1'b0, ra[64:30]});
    sb   = negb_r ? -$signed({1'b0, rb[64:30]}) : $signed({1'b0, rb[64:30]});
    dstr = $signed({3'b0, len_r}) - $signed({{4{x_r[31]}}, x_r});
    unique case (mode_r)
      bcw_pkg::MODE_BEND: begin
        bx_nxt = bcw_pkg::sat_coord(sa);
        by_nxt = bcw_pkg::sat_coord(sb);
      end
      bcw_pkg::MODE_STRAIGHT: begin
        bx_nxt = y_r;
        by_nxt = bcw_pkg::sat_coord(dstr);
      end
      default: begin
        bx_nxt = x_r;
        by_nxt = y_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= up_valid;
      if (rdy_b) vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      pa_r   <= ay[31:0] * acx[31:0];
      pb_r   <= ay[31:0] * acy[31:0];
      nega_r <= up_item.y[31] != up_item.cx[33];
      negb_r <= up_item.y[31] != up_item.cy[33];
      mode_r <= up_item.mode;
      x_r    <= up_item.x;
      y_r    <= up_item.y;
      len_r  <= up_item.len;
    end
    if (rdy_b) begin
      bx_r <= bx_nxt;
      by_r <= by_nxt;
    end
  end

endmodule

### rtl/pipe_bend_coordinate_warp_core.sv
`timescale 1ns / 1ps
// Channel | Dir | Payload                    | Transaction
// in_ch   | in  | coord_x, coord_y           | valid && ready
// out_ch  | out | bent_x, bent_y             | valid && ready
// cfg     | in  | cfg_wr_data (bend_radius)  | cfg_wr_en
// One transaction per cycle sustained while out_ch is ready; items pass the front
// stages, 30 divider cells, the angle stage, 16 CORDIC cells and product stages.
// Every stage holds its item and advances when the next stage is empty or moving.
// Synchronous active-low reset clears valid bits and loads radius 1.0.
module pipe_bend_coordinate_warp_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [bcw_pkg::RADIUS_W-1:0]  cfg_wr_data,
  bcw_in_if.sink                        in_ch,
  bcw_out_if.source                     out_ch
);

  localparam int NC = bcw_pkg::DIV_CELLS + 1 + bcw_pkg::CORDIC_N;

  logic [bcw_pkg::RADIUS_W-1:0] radius_r;
  logic           v [NC+1];
  logic           r [NC+1];
  bcw_pkg::item_t it [NC+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= bcw_pkg::RADIUS_RST;
    end else if (cfg_wr_en) begin
      radius_r <= cfg_wr_data;
    end
  end

  bcw_front u_front (
    .clk, .rst_n, .bend_radius(radius_r),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_x(in_ch.coord_x), .in_y(in_ch.coord_y),
    .dn_valid(v[0]), .dn_ready(r[0]), .dn_item(it[0])
  );

  for (genvar i = 0; i < bcw_pkg::DIV_CELLS; i++) begin : g_div
    bcw_div_cell u_cell (
      .clk, .rst_n,
      .up_valid(v[i]), .up_ready(r[i]), .up_item(it[i]),
      .dn_valid(v[i+1]), .dn_ready(r[i+1]), .dn_item(it[i+1])
    );
  end

  bcw_angle u_angle (
    .clk, .rst_n,
    .up_valid(v[bcw_pkg::DIV_CELLS]), .up_ready(r[bcw_pkg::DIV_CELLS]),
    .up_item(it[bcw_pkg::DIV_CELLS]),
    .dn_valid(v[bcw_pkg::DIV_CELLS+1]), .dn_ready(r[bcw_pkg::DIV_CELLS+1]),
    .dn_item(it[bcw_pkg::DIV_CELLS+1])
  );

  for (genvar k = 0; k < bcw_pkg::CORDIC_N; k++) begin : g_cordic
    localparam int P = bcw_pkg::DIV_CELLS + 1 + k;
    bcw_cordic_cell u_cell (
      .clk, .rst_n, .step(bcw_pkg::STEP_W'(k)),
      .up_valid(v[P]), .up_ready(r[P]), .up_item(it[P]),
      .dn_valid(v[P+1]), .dn_ready(r[P+1]), .dn_item(it[P+1])
    );
  end

  bcw_back u_back (
    .clk, .rst_n,
    .up_valid(v[NC]), .up_ready(r[NC]), .up_item(it[NC]),
    .dn_valid(out_ch.valid), .dn_ready(out_ch.ready),
    .dn_x(out_ch.bent_x), .dn_y(out_ch.bent_y)
  );

endmodule

### rtl/bcw_checker.sv
`timescale 1ns / 1ps
`include "pipe_bend_coordinate_warp_core_macros.svh"
module bcw_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [bcw_pkg::COORD_W-1:0] out_x,
  input logic signed [bcw_pkg::COORD_W-1:0] out_y
);

  `BCW_ASSERT_RST(a_rst_empty, !out_valid)
  `BCW_ASSERT_IMPL(a_drain_ready, out_ready || !out_valid, in_ready)
  `BCW_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_x) && $stable(out_y))
  `BCW_ASSERT_IMPL(a_known, out_valid, !$isunknown(out_x) && !$isunknown(out_y))

endmodule

bind pipe_bend_coordinate_warp_core bcw_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_x(out_ch.bent_x), .out_y(out_ch.bent_y)
);

### verif/tb.sv
`timescale 1ns / 1ps
module tb;

  typedef struct {
    logic signed [bcw_pkg::COORD_W-1:0] bx;
    logic signed [bcw_pkg::COORD_W-1:0] by;
  } bent_pt_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [bcw_pkg::RADIUS_W-1:0] cfg_wr_data = '0;

  bcw_in_if in_if();
  bcw_out_if out_if();

  pipe_bend_coordinate_warp_core dut (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_ch(in_if), .out_ch(out_if)
  );

  always #5 clk = ~clk;

  localparam longint unsigned HP = 64'd1686629713;
  localparam int LIMIT = 2000000;
  localparam int DRAIN = 80;

  longint atan_tab [16] = '{843314857, 497837829, 263043837, 133525159, 67021687,
    33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
    131072, 65536, 32768};

  logic [bcw_pkg::RADIUS_W-1:0] radius;
  bent_pt_t bent_q[$];
  int errors = 0;
  int cycles = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int hold_cycles = 0;

  function automatic longint bend_len(input logic [bcw_pkg::RADIUS_W-1:0] r);
    longint unsigned p;
    p = longint'(r) * HP + (64'd1 << 29);
    return longint'(p >> 30);
  endfunction

  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint round_mul(input longint a, input longint c);
    longint unsigned ma, mc, m;
    logic neg;
    neg = (a < 0) != (c < 0);
    ma = a < 0 ? -a : a;
    mc = c < 0 ? -c : c;
    m = (ma * mc + (64'd1 << 29)) >> 30;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic bent_pt_t warp_point(input logic signed [bcw_pkg::COORD_W-1:0] xi,
                                          input logic signed [bcw_pkg::COORD_W-1:0] yi);
    bent_pt_t res;
    longint x, y, len, z, cx, cy, dx, dy;
    longint unsigned rem, frac;
    x = longint'(xi);
    y = longint'(yi);
    len = bend_len(radius);
    if (x <= 0) begin
      res.bx = xi;
      res.by = yi;
    end else if (x <= len) begin
      rem = len - x;
      frac = 0;
      for (int i = 0; i < 30; i++) begin
        rem = rem << 1;
        frac = frac << 1;
        if (rem >= longint'(len)) begin
          rem -= len;
          frac |= 1;
        end
      end
      z = longint'((frac * HP + (64'd1 << 29)) >> 30);
      cx = 652032874;
      cy = 0;
      for (int i = 0; i < 16; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (z >= 0) begin
          cx -= dx; cy += dy; z -= atan_tab[i];
        end else begin
          cx += dx; cy -= dy; z += atan_tab[i];
        end
      end
      res.bx = 32'(sat32(round_mul(y, cx)));
      res.by = 32'(sat32(round_mul(y, cy)));
    end else begin
      res.bx = yi;
      res.by = 32'(sat32(len - x));
    end
    return res;
  endfunction

  initial begin
    in_if.valid = 1'b0;
    in_if.coord_x = '0;
    in_if.coord_y = '0;
    out_if.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_if.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    bent_pt_t exp_pt;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (bent_q.size() == 0) begin
        $display("%0t: unexpected transaction %h %h", $time, out_if.bent_x, out_if.bent_y);
        errors++;
      end else begin
        exp_pt = bent_q.pop_front();
        if (out_if.bent_x !== exp_pt.bx) begin
          $display("%0t: bent_x expected %h actual %h", $time, exp_pt.bx, out_if.bent_x);
          errors++;
        end
        if (out_if.bent_y !== exp_pt.by) begin
          $display("%0t: bent_y expected %h actual %h", $time, exp_pt.by, out_if.bent_y);
          errors++;
        end
      end
    end
  end

  task automatic send_point(input logic signed [bcw_pkg::COORD_W-1:0] x,
                            input logic signed [bcw_pkg::COORD_W-1:0] y);
    while ($urandom_range(99) < send_idle) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.coord_x = x;
    in_if.coord_y = y;
    do @(posedge clk); while (!in_if.ready);
    bent_q.push_back(warp_point(x, y));
    @(negedge clk);
  endtask

  task automatic drain_pipe();
    in_if.valid = 1'b0;
    wait (bent_q.size() == 0);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic set_radius(input logic [bcw_pkg::RADIUS_W-1:0] r);
    drain_pipe();
    cfg_wr_en = 1'b1;
    cfg_wr_data = r;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    radius = r;
  endtask

  function automatic logic signed [bcw_pkg::COORD_W-1:0] rand_y();
    case ($urandom_range(3))
      0: return $urandom_range(2 * 65536) - 65536;
      1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [bcw_pkg::COORD_W-1:0] rand_x();
    longint len;
    len = bend_len(radius);
    case ($urandom_range(9))
      0, 1: return -$signed({1'b0, 31'($urandom)});
      2: return 32'($urandom_range(0, 1) ? len : len + 1);
      3: return $urandom;
      4, 5: return (len > 64'sd2147483647) ? $signed({1'b0, 31'($urandom)}) :
                   32'(len + 1 + $urandom_range(32'h7fffffff - 32'(len)));
      default: return (len >= 64'sd2147483647) ? 32'($urandom_range(1, 32'h7fffffff)) :
                      32'($urandom_range(1, 32'(len)));
    endcase
  endfunction

  task automatic test_directed();
    longint len;
    len = bend_len(radius);
    send_point(0, 65536);
    send_point(32'sh80000000, 32'sh7fffffff);
    send_point(-1, 32'sh80000000);
    send_point(1, 65536);
    send_point(32'(len), 65536);
    send_point(32'(len + 1), 32'sh80000000);
    send_point(32'(len / 2), 32'sh7fffffff);
    send_point(32'(len / 2), 32'sh80000000);
    send_point(32'sh7fffffff, 32'sh7fffffff);
    send_point(32'sh7fffffff, -1);
    send_point(32'(len / 3), -65536);
  endtask

  task automatic test_random(input int n);
    repeat (n) send_point(rand_x(), rand_y());
  endtask

  task automatic test_backpressure();
    hold_cycles = 300;
    test_random(120);
  endtask

  task automatic test_radius_sweep();
    set_radius(31'd1);
    test_directed();
    test_random(120);
    set_radius(31'h7fffffff);
    test_directed();
    test_random(120);
    set_radius(31'd10 << 16);
    test_random(120);
    set_radius(31'($urandom_range(1, 32'h7fffffff)));
    test_random(120);
  endtask

  initial begin
    radius = bcw_pkg::RADIUS_RST;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    send_idle = 37;
    recv_idle = 62;
    test_directed();
    test_random(150);
    send_idle = 62;
    recv_idle = 37;
    test_radius_sweep();
    send_idle = 0;
    recv_idle = 0;
    set_radius(31'd65536);
    test_random(150);
    test_backpressure();
    drain_pipe();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
